// ===== rtl/core/be3_pkg.sv =====
// be3_pkg: shared constants and types for the 3x3 binary erosion block.
// No dependencies.
package be3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W = 8;
  localparam int DIM_W = 11;                    // frame_width / frame_height registers
  localparam int COL_W = $clog2(MAX_WIDTH);     // column index
  localparam int ROW_W = $clog2(MAX_HEIGHT);    // output row index
  localparam int IN_ROW_W = ROW_W + 1;          // input row runs into the drain rows

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } be3_reg_t;

  // Per-item control, decided at accept time from the position counters.
  typedef struct packed {
    logic drop;       // drain tick while pixels are still expected
    logic drain;      // frame pixels done, item carries a zero pixel
    logic emit;       // item produces a result
    logic frame_end;  // that result is the last of the frame
    logic top_ok;     // neighbor row above lies inside the frame
    logic bot_ok;     // neighbor row below lies inside the frame
    logic left_ok;    // neighbor column left lies inside the frame
    logic right_ok;   // neighbor column right lies inside the frame
  } be3_info_t;

endpackage

// ===== rtl/core/be3_line_ram.sv =====
// be3_line_ram: generic single-port-write, single-port-read RAM, registered read.
// Read-first on a same-address collision. No package dependencies.
module be3_line_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/be3_pos.sv =====
// be3_pos: frame geometry registers and input/output position counters.
// Depends on be3_pkg.
module be3_pos import be3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_wdata,
  input  logic             cmd,      // cmd of the item on offer
  input  logic             adv,      // item taken into the pipeline
  output logic [COL_W-1:0] col,      // line store column of the item on offer
  output be3_info_t        info
);

  logic [DIM_W-1:0]    w_r, h_r;
  logic [COL_W-1:0]    in_col_r, in_col_nxt;
  logic [IN_ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  logic                in_col_last, out_col_last, out_row_last;

  // 0 reads as 1, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  assign in_col_last  = ({1'b0, in_col_r} == w_r - DIM_W'(1));
  assign out_col_last = ({1'b0, out_col_r} == w_r - DIM_W'(1));
  assign out_row_last = ({1'b0, out_row_r} == h_r - DIM_W'(1));
  assign col = in_col_r;

  always_comb begin
    info.drain     = (in_row_r >= h_r);
    info.drop      = cmd && !info.drain;
    info.emit      = (in_row_r > IN_ROW_W'(1)) ||
                     ((in_row_r == IN_ROW_W'(1)) && (in_col_r != '0));
    info.frame_end = out_col_last && out_row_last;
    info.top_ok    = (out_row_r != '0);
    info.bot_ok    = !out_row_last;
    info.left_ok   = (out_col_r != '0);
    info.right_ok  = !out_col_last;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (adv) begin
      if (in_col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + IN_ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (info.emit) begin
        if (out_col_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
        if (info.frame_end) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= RESET_WIDTH;
      h_r       <= RESET_HEIGHT;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_we) begin
      unique case (be3_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  w_r <= clamp_dim(cfg_wdata, DIM_W'(MAX_WIDTH));
        REG_FRAME_HEIGHT: h_r <= clamp_dim(cfg_wdata, DIM_W'(MAX_HEIGHT));
        default: ;
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

// ===== rtl/core/binary_erosion_3x3.sv =====
// binary_erosion_3x3: 8-neighbor erosion of 8-bit raster pixels, 3x3 window.
// Throughput: one item per cycle unless out_tready stalls. A result is formed in
// stage 1 with the item W + 1 after its pixel (W = frame width) and registered.
// Reset: geometry returns to 640 x 480, all position counters clear. The line store
// is not cleared; entries not yet written this frame only feed masked neighbors.
// Depends on be3_pkg, be3_pos, be3_line_ram.
module binary_erosion_3x3 import be3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // configuration write port
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_wdata,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] pixel_in
  input  logic             in_tuser,   // cmd: 0 pixel, 1 drain tick
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [7:0] pixel_out
  output logic             out_tlast   // frame_end
);

  // ---------------------------------------------------------------------------
  // Position tracking: decides per item whether it is dropped, drained, and
  // which window neighbors lie inside the frame for the result it produces.
  // ---------------------------------------------------------------------------
  be3_info_t        info;
  logic [COL_W-1:0] col;
  logic             in_fire, load;

  assign in_fire = in_tvalid && in_tready;
  assign load    = in_fire && !info.drop;   // dropped items leave no trace

  be3_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (in_tuser),
    .adv       (load),
    .col       (col),
    .info      (info)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: item register. The line store read issued at accept lands here
  // at the same time. Word layout: [15:8] upper row, [7:0] middle row.
  // ---------------------------------------------------------------------------
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  be3_info_t        s1_info_r;
  logic             s1_adv;

  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] ram_wdata;
  logic [PIX_W-1:0]   up_col, mid_col;

  // Bypass: with a one-pixel-wide frame the next item reads the column being
  // written in the same cycle, so the written word is forwarded.
  logic               byp_r;
  logic [2*PIX_W-1:0] byp_data_r;

  assign up_col    = byp_r ? byp_data_r[2*PIX_W-1:PIX_W] : ram_rdata[2*PIX_W-1:PIX_W];
  assign mid_col   = byp_r ? byp_data_r[PIX_W-1:0]       : ram_rdata[PIX_W-1:0];
  assign ram_wdata = {mid_col, s1_pix_r};   // middle row moves up, new pixel in

  // Stage 1 needs the output register only when it produces a result.
  assign s1_adv    = s1_valid_r && (!s1_info_r.emit || !out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  be3_line_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (load),
    .raddr (col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
        byp_r      <= s1_adv && (s1_col_r == col);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_pix_r   <= info.drain ? '0 : in_tdata[PIX_W-1:0];
      s1_col_r   <= col;
      s1_info_r  <= info;
      byp_data_r <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Window: the two newest columns are kept; the incoming column comes from
  // stage 1. After the shift, the middle column's center is the pixel judged.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] win1_r [3];   // column left of center after the shift
  logic [PIX_W-1:0] win2_r [3];   // center column after the shift
  logic [PIX_W-1:0] centre, res;
  logic             any_zero;

  assign centre = win2_r[1];

  always_comb begin
    any_zero = 1'b0;
    if (s1_info_r.top_ok) begin
      if (s1_info_r.left_ok && win1_r[0] == '0)  any_zero = 1'b1;
      if (win2_r[0] == '0)                       any_zero = 1'b1;
      if (s1_info_r.right_ok && up_col == '0)    any_zero = 1'b1;
    end
    if (s1_info_r.left_ok && win1_r[1] == '0)    any_zero = 1'b1;
    if (s1_info_r.right_ok && mid_col == '0)     any_zero = 1'b1;
    if (s1_info_r.bot_ok) begin
      if (s1_info_r.left_ok && win1_r[2] == '0)  any_zero = 1'b1;
      if (win2_r[2] == '0)                       any_zero = 1'b1;
      if (s1_info_r.right_ok && s1_pix_r == '0)  any_zero = 1'b1;
    end
    res = (centre == PIX_MAX && any_zero) ? '0 : centre;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win1_r    <= win2_r;
      win2_r[0] <= up_col;
      win2_r[1] <= mid_col;
      win2_r[2] <= s1_pix_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_last_r;
  logic             out_load;

  assign out_load = s1_adv && s1_info_r.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r  <= res;
      out_last_r <= s1_info_r.frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule
